// ===== hdl/ulst_pkg.sv =====
`timescale 1ns / 1ps

package ulst_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_NEXT    = 3'd4,
    CMD_CLEAR   = 3'd5
  } ulst_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_END       = 2'd3
  } ulst_status_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [KEY_W-1:0]  item_key;
    logic [DATA_W-1:0] item_data;
  } ulst_req_t;

  typedef struct packed {
    logic              found;
    logic [KEY_W-1:0]  out_key;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  entry_count;
    logic [1:0]        status;
  } ulst_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } ulst_entry_t;

  // per-cell control from the list controller
  typedef struct packed {
    logic shift_in;   // take the entry from the head side
    logic shift_out;  // take the entry from the tail side
    logic clr;        // drop the entry
    logic sel;        // drive the entry onto the read bus
  } ulst_cell_ctrl_t;

endpackage

// ===== hdl/ulst_cell.sv =====
`timescale 1ns / 1ps

module ulst_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ulst_pkg::ulst_cell_ctrl_t ctrl_i,
  input  logic [ulst_pkg::KEY_W-1:0] key_i,
  input  ulst_pkg::ulst_entry_t   head_i,
  input  ulst_pkg::ulst_entry_t   tail_i,
  output ulst_pkg::ulst_entry_t   entry_o,
  output logic                    match_o,
  output ulst_pkg::ulst_entry_t   rd_o
);
  import ulst_pkg::*;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift_in) begin
      valid_d = head_i.valid;
      key_d   = head_i.key;
      data_d  = head_i.data;
    end else if (ctrl_i.shift_out) begin
      valid_d = tail_i.valid;
      key_d   = tail_i.key;
      data_d  = tail_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, data: data_q};
  assign match_o = valid_q && (key_q == key_i);
  assign rd_o    = ctrl_i.sel ? entry_o : '0;

endmodule

// ===== hdl/unsorted_list_table.sv =====
`timescale 1ns / 1ps

// Channel   Ports                   Handshake
// command   start, req_i            beat taken when start && !busy
// result    done_o, rsp_o           beat shown for one cycle, done_o high
//
// A command is handled as follows: the accept edge registers it, and in the
// following cycle every cell compares its key in parallel while the
// controller picks the newest match and shifts the row; the result shows in
// the cycle after that, with busy already low so the next beat is taken at
// its closing edge. Reset clears valid bits, count and iterator at once, no
// clearing pass. The receiver cannot stall: a result lasts one strobe cycle.
module unsorted_list_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ulst_pkg::ulst_req_t  req_i,
  output logic                 done_o,
  output ulst_pkg::ulst_rsp_t  rsp_o
);
  import ulst_pkg::*;

  // command register, live while busy
  logic      op_valid_q;
  ulst_req_t op_q;

  logic [CNT_W-1:0] count_q, count_d;
  // index of the entry that next returns; restart and clear set it to zero
  logic [CNT_W-1:0] iter_q, iter_d;

  logic      done_q;
  ulst_rsp_t rsp_q, rsp_d;

  ulst_entry_t     cell_entry [DEPTH];
  ulst_entry_t     cell_rd    [DEPTH];
  ulst_cell_ctrl_t cell_ctrl  [DEPTH];
  logic [DEPTH-1:0] match;

  logic [DEPTH-1:0] hit_oh, hit_ge, iter_oh;
  logic [IDX_W-1:0] hit_idx;
  logic             any_hit, full, iter_ok;
  ulst_entry_t      rd_bus;
  logic             do_ins, do_del, do_clr, is_next;

  assign busy   = op_valid_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---- cell row: head is cell 0 ----
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ulst_entry_t head_in, tail_in;
    if (g == 0) begin : g_head
      assign head_in = '{valid: 1'b1, key: op_q.item_key, data: op_q.item_data};
    end else begin : g_mid
      assign head_in = cell_entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign tail_in = '0;
    end else begin : g_body
      assign tail_in = cell_entry[g+1];
    end

    ulst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .key_i   (op_q.item_key),
      .head_i  (head_in),
      .tail_i  (tail_in),
      .entry_o (cell_entry[g]),
      .match_o (match[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // ---- match select and iterator decode ----
  assign hit_oh  = match & (~match + DEPTH'(1));      // newest (lowest) match
  assign hit_ge  = ~(hit_oh - DEPTH'(1));             // cells at or behind it
  assign any_hit = |match;
  assign full    = (count_q == CNT_W'(DEPTH));
  assign iter_ok = (iter_q < count_q);

  always_comb begin
    hit_idx = '0;
    iter_oh = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_oh[i]) hit_idx = hit_idx | IDX_W'(i);
      iter_oh[i] = (iter_q == CNT_W'(i));
    end
  end

  assign is_next = op_valid_q && (op_q.cmd == CMD_NEXT);
  assign do_ins  = op_valid_q && (op_q.cmd == CMD_INSERT) && !full;
  assign do_del  = op_valid_q && (op_q.cmd == CMD_DELETE) && any_hit;
  assign do_clr  = op_valid_q && (op_q.cmd == CMD_CLEAR);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].shift_in  = do_ins;
      cell_ctrl[i].shift_out = do_del && hit_ge[i];
      cell_ctrl[i].clr       = do_clr;
      cell_ctrl[i].sel       = is_next ? iter_oh[i] : hit_oh[i];
    end
  end

  // read bus: OR of the selected cell
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // ---- result and bookkeeping ----
  always_comb begin
    count_d         = count_q;
    iter_d          = iter_q;
    rsp_d.found     = 1'b0;
    rsp_d.out_key   = op_q.item_key;
    rsp_d.out_data  = '0;
    rsp_d.status    = ST_OK;
    case (op_q.cmd)
      CMD_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
          // iterator stays on the same entry, which moved one place back
          if (iter_q != '0) iter_d = iter_q + CNT_W'(1);
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        if (any_hit) begin
          rsp_d.found    = 1'b1;
          rsp_d.out_key  = rd_bus.key;
          rsp_d.out_data = rd_bus.data;
          if (op_q.cmd == CMD_DELETE) begin
            count_d = count_q - CNT_W'(1);
            if (CNT_W'(hit_idx) < iter_q) iter_d = iter_q - CNT_W'(1);
          end
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      CMD_RESTART: begin
        iter_d = '0;
      end
      CMD_NEXT: begin
        if (iter_ok) begin
          rsp_d.out_key  = rd_bus.key;
          rsp_d.out_data = rd_bus.data;
          iter_d         = iter_q + CNT_W'(1);
        end else begin
          rsp_d.status = ST_END;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
        iter_d  = '0;
      end
      default: begin
        // unused codes change nothing
      end
    endcase
    rsp_d.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
      done_q     <= 1'b0;
      count_q    <= '0;
      iter_q     <= '0;
    end else begin
      done_q <= op_valid_q;
      if (op_valid_q) begin
        op_valid_q <= 1'b0;
        count_q    <= count_d;
        iter_q     <= iter_d;
      end else if (start) begin
        op_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !op_valid_q) begin
      op_q <= req_i;
    end
    if (op_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// ===== hdl/ulst_checker.sv =====
`timescale 1ns / 1ps

module ulst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input ulst_pkg::ulst_req_t req_i,
  input logic                done_o,
  input ulst_pkg::ulst_rsp_t rsp_o
);
  import ulst_pkg::*;

  // a taken command goes busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  // busy for a single compute cycle, then a result beat with busy low
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result beat missing after compute cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_FULL |-> rsp_o.entry_count == CNT_W'(DEPTH)
      && $past(req_i.cmd, 2) == CMD_INSERT)
    else $error("full status without a full list");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.found |-> rsp_o.status == ST_OK)
    else $error("found with a non-ok status");

endmodule

bind unsorted_list_table ulst_checker u_ulst_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== sim/ulst_list_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of unsorted_list_table, keeps a shadow of the list,
// and compares every result beat with the oldest outstanding prediction.
module ulst_list_checker
  import ulst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  ulst_req_t   req_i,
  input  logic        done_i,
  input  ulst_rsp_t   rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned hits_o,
  output int unsigned dropped_o,
  output int unsigned walk_ends_o
);

  // shadow list, index 0 is the newest entry
  logic [KEY_W-1:0]  list_key  [DEPTH];
  logic [DATA_W-1:0] list_data [DEPTH];
  int                list_len;
  int                walk_pos;   // index of the entry the next command returns
  ulst_rsp_t         awaited_rsp [$];

  function automatic ulst_rsp_t apply_command(ulst_req_t req);
    ulst_rsp_t rsp;
    int        hit;
    rsp         = '0;
    rsp.out_key = req.item_key;
    rsp.status  = ST_OK;
    hit         = -1;
    // newest match wins: scan from the tail so the lowest index sticks
    for (int i = list_len - 1; i >= 0; i--) begin
      if (list_key[i] == req.item_key) hit = i;
    end
    case (req.cmd)
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) begin
            list_key[i]  = list_key[i-1];
            list_data[i] = list_data[i-1];
          end
          list_key[0]  = req.item_key;
          list_data[0] = req.item_data;
          list_len++;
          if (walk_pos > 0 && walk_pos < list_len) walk_pos++;
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        if (hit < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.found    = 1'b1;
          rsp.out_key  = list_key[hit];
          rsp.out_data = list_data[hit];
          if (req.cmd == CMD_DELETE) begin
            for (int i = hit; i + 1 < list_len; i++) begin
              list_key[i]  = list_key[i+1];
              list_data[i] = list_data[i+1];
            end
            list_len--;
            if (hit < walk_pos) walk_pos--;
          end
        end
      end
      CMD_RESTART: walk_pos = 0;
      CMD_NEXT: begin
        if (walk_pos < list_len) begin
          rsp.out_key  = list_key[walk_pos];
          rsp.out_data = list_data[walk_pos];
          walk_pos++;
        end else begin
          rsp.status = ST_END;
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
        walk_pos = 0;
      end
      default: ;
    endcase
    rsp.entry_count = CNT_W'(list_len);
    return rsp;
  endfunction

  function automatic int compare_rsp(ulst_rsp_t want, ulst_rsp_t got);
    int bad;
    bad = 0;
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      bad++;
    end
    if (got.out_key !== want.out_key) begin
      $error("out_key: expected %h, got %h", want.out_key, got.out_key);
      bad++;
    end
    if (got.out_data !== want.out_data) begin
      $error("out_data: expected %h, got %h", want.out_data, got.out_data);
      bad++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      bad++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int        bad;
    ulst_rsp_t want;
    if (!rst_ni) begin
      list_len = 0;
      walk_pos = 0;
      awaited_rsp.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      hits_o       <= 0;
      dropped_o    <= 0;
      walk_ends_o  <= 0;
    end else begin
      bad = 0;
      // result first: it belongs to a command taken at an earlier edge
      if (done_i) begin
        if (awaited_rsp.size() == 0) begin
          $error("result beat with nothing outstanding: out_key %h", rsp_i.out_key);
          bad = 1;
        end else begin
          want = awaited_rsp.pop_front();
          bad  = compare_rsp(want, rsp_i);
          checked_o   <= checked_o + 1;
          hits_o      <= hits_o + want.found;
          dropped_o   <= dropped_o + (want.status == ST_FULL);
          walk_ends_o <= walk_ends_o + (want.status == ST_END);
        end
      end
      if (start_i && !busy_i) awaited_rsp.push_back(apply_command(req_i));
      fail_count_o <= fail_count_o + bad;
      pending_o    <= awaited_rsp.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Top of the unsorted_list_table bench. Drives the command channel only;
// prediction and comparison live in ulst_list_checker.
module tb;
  import ulst_pkg::*;

  localparam int unsigned RANDOM_CMDS   = 1800;
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_LIMIT   = 200;
  localparam int unsigned SETTLE_CYCLES = 8;

  // stimulus flavors; a fill phase pushes the list to full, a drain phase
  // empties it, a walk phase exercises the iterator
  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_WALK, PH_MIX} phase_e;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ulst_req_t req_i;
  logic      done_o;
  ulst_rsp_t rsp_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;
  int unsigned dropped;
  int unsigned walk_ends;

  int unsigned sent_per_cmd [6];
  int unsigned sent_total;
  int unsigned idle_cycles;
  bit          no_idle;   // set for stretches of back-to-back commands

  unsorted_list_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  ulst_list_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .hits_o       (hits),
    .dropped_o    (dropped),
    .walk_ends_o  (walk_ends)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a correct run never goes long without a beat on one side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("unsorted_list_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap after a beat: mostly none or short, now and then a long one so
  // the idle spell lands on every phase of a command.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Keys mostly from a tiny pool so lookups and deletes hit and duplicates
  // pile up; the rest spread over the whole field to toggle every bit.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return KEY_W'($urandom_range(0, 7));
    if (r < 75) return '0;
    if (r < 80) return '1;
    return KEY_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return '1;
    return DATA_W'($urandom);
  endfunction

  function automatic ulst_cmd_e pick_cmd(phase_e phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 65) return CMD_INSERT;
        if (r < 82) return CMD_LOOKUP;
        if (r < 92) return CMD_NEXT;
        return CMD_DELETE;
      end
      PH_DRAIN: begin
        if (r < 55) return CMD_DELETE;
        if (r < 75) return CMD_LOOKUP;
        if (r < 88) return CMD_NEXT;
        if (r < 95) return CMD_INSERT;
        return CMD_RESTART;
      end
      PH_WALK: begin
        // inserts and deletes mid-walk move the iterator around
        if (r < 70) return CMD_NEXT;
        if (r < 80) return CMD_INSERT;
        if (r < 90) return CMD_DELETE;
        if (r < 96) return CMD_LOOKUP;
        return CMD_RESTART;
      end
      default: begin
        if (r < 25) return CMD_INSERT;
        if (r < 45) return CMD_LOOKUP;
        if (r < 65) return CMD_DELETE;
        if (r < 75) return CMD_RESTART;
        if (r < 95) return CMD_NEXT;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  // One command beat. start is raised at a clock edge and held until an
  // edge sees busy low. With no gap start stays high for the next beat, so
  // it is never dropped and raised in one time step.
  task automatic send_cmd(ulst_cmd_e cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
    int unsigned gap;
    gap   = no_idle ? 0 : pick_gap();
    start <= 1'b1;
    req_i <= '{cmd: cmd, item_key: key, item_data: data};
    do @(posedge clk_i); while (busy !== 1'b0);
    sent_per_cmd[cmd]++;
    sent_total++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the command side until every outstanding result has come back.
  // Always steps at least one edge so start is not re-raised in this step.
  task automatic settle_out();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    phase_e      phase;
    int unsigned phase_len;
    int unsigned directed_sent;
    bit          first;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: empty list corners ---
    send_cmd(CMD_NEXT,    16'h1357, 16'h2468);  // next on empty -> end
    send_cmd(CMD_LOOKUP,  16'hABCD, 16'h0000);  // lookup on empty -> not found
    send_cmd(CMD_DELETE,  16'h0000, 16'hFFFF);  // delete on empty -> not found
    send_cmd(CMD_RESTART, 16'hFFFF, 16'hFFFF);
    // extremes of key and data, then a duplicate key that must shadow the older one
    send_cmd(CMD_INSERT,  16'h0000, 16'h0000);
    send_cmd(CMD_INSERT,  16'hFFFF, 16'hFFFF);
    send_cmd(CMD_INSERT,  16'h0000, 16'h1234);
    send_cmd(CMD_LOOKUP,  16'h0000, 16'h0000);  // newest match
    send_cmd(CMD_LOOKUP,  16'hFFFF, 16'h0000);
    send_cmd(CMD_LOOKUP,  16'h5555, 16'h0000);  // miss on non-empty list
    send_cmd(CMD_DELETE,  16'h5555, 16'h0000);
    // iterator: insert mid-walk keeps its place, delete behind it pulls it back
    send_cmd(CMD_RESTART, 16'h0000, 16'h0000);
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);
    send_cmd(CMD_INSERT,  16'h0007, 16'h00A5);
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);
    send_cmd(CMD_DELETE,  16'hFFFF, 16'h0000);
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);  // past the tail
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);  // iterator stays at the end
    send_cmd(CMD_DELETE,  16'h0000, 16'h0000);
    // clear empties the list and rewinds the walk
    send_cmd(CMD_CLEAR,   16'h00FF, 16'hFF00);
    send_cmd(CMD_NEXT,    16'h0000, 16'h0000);
    send_cmd(CMD_LOOKUP,  16'h0007, 16'h0000);
    settle_out();
    directed_sent = sent_total;

    // --- random phases ---
    // First phase is a fill of 40 commands so the full-list drop shows up early;
    // after that the flavor and length are drawn per phase; the idling style is drawn for every phase.
    first = 1'b1;
    while (sent_total - directed_sent < RANDOM_CMDS) begin
      phase     = first ? PH_FILL : phase_e'($urandom_range(0, 3));
      phase_len = first ? 40 : $urandom_range(10, 60);
      no_idle   = ($urandom_range(0, 3) == 0);
      if (phase == PH_WALK) send_cmd(CMD_RESTART, pick_key(), pick_data());
      repeat (phase_len) send_cmd(pick_cmd(phase), pick_key(), pick_data());
      if (first || $urandom_range(0, 3) == 0) settle_out();
      first = 1'b0;
    end

    // --- wind down: let the last results arrive ---
    start <= 1'b0;
    @(posedge clk_i);
    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d commands: insert %0d, lookup %0d, delete %0d, restart %0d, next %0d, clear %0d",
             sent_total, sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_LOOKUP],
             sent_per_cmd[CMD_DELETE], sent_per_cmd[CMD_RESTART], sent_per_cmd[CMD_NEXT],
             sent_per_cmd[CMD_CLEAR]);
    $display("%0d results compared: %0d key hits, %0d inserts dropped on full, %0d walks off the end",
             checked, hits, dropped, walk_ends);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("unsorted_list_table regression: pass");
    end else begin
      $display("unsorted_list_table regression: fail");
    end
    $finish;
  end

endmodule
